>>> src/fmr_pkg.sv
`timescale 1ns / 1ps

package fmr_pkg;

  // Width of each operand field on the input word
  localparam int OperandWidth = 16;
  // Width of each reduced field on the output word
  localparam int ResultWidth = 32;
  localparam int DefaultOperandWidth = 16;
  localparam int DefaultProdWidth = 2 * OperandWidth;

  typedef struct packed {
    logic [OperandWidth-1:0] num_a;
    logic [OperandWidth-1:0] den_a;
    logic [OperandWidth-1:0] num_b;
    logic [OperandWidth-1:0] den_b;
  } in_t;

  typedef struct packed {
    logic [ResultWidth-1:0] num_out;
    logic [ResultWidth-1:0] den_out;
    logic                   zero_error;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_NUM,
    ST_MUL_DEN,
    ST_START,
    ST_RUN,
    ST_PUSH
  } fmr_state_e;

  typedef enum logic [2:0] {
    EN_IDLE,
    EN_TWOS,
    EN_REDUCE,
    EN_DIV_NUM,
    EN_DIV_DEN,
    EN_DONE
  } fmr_eng_state_e;

endpackage

>>> src/fmr_engine.sv
`timescale 1ns / 1ps

module fmr_engine #(
  parameter int PROD_WIDTH = fmr_pkg::DefaultProdWidth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [PROD_WIDTH-1:0] pn_i,
  input  logic [PROD_WIDTH-1:0] pd_i,
  output logic                  done_o,
  output logic [PROD_WIDTH-1:0] quo_num_o,
  output logic [PROD_WIDTH-1:0] quo_den_o
);

  localparam int CntW = $clog2(PROD_WIDTH);

  fmr_pkg::fmr_eng_state_e state_q, state_d;

  logic [PROD_WIDTH-1:0] a_q, a_d;
  logic [PROD_WIDTH-1:0] b_q, b_d;
  logic [PROD_WIDTH-1:0] rn_q, rn_d;
  logic [PROD_WIDTH-1:0] rd_q, rd_d;
  logic [PROD_WIDTH-1:0] rem_q, rem_d;
  logic [PROD_WIDTH-1:0] quo_q, quo_d;
  logic [PROD_WIDTH-1:0] qn_q, qn_d;
  logic [CntW-1:0]       cnt_q, cnt_d;

  logic                  a_gt_b;
  logic                  a_eq_b;
  logic                  both_even;
  logic                  div_last;
  logic [PROD_WIDTH:0]   sub_x;
  logic [PROD_WIDTH:0]   sub_y;
  logic [PROD_WIDTH:0]   diff;
  logic                  borrow;
  logic [PROD_WIDTH-1:0] step_rem;
  logic [PROD_WIDTH-1:0] step_quo;

  assign a_gt_b    = a_q > b_q;
  assign a_eq_b    = a_q == b_q;
  assign both_even = !a_q[0] && !b_q[0];
  assign div_last  = cnt_q == CntW'(PROD_WIDTH - 1);

  // Shared subtractor: larger minus smaller during gcd, trial subtract during divide
  always_comb begin
    sub_x = {rem_q, quo_q[PROD_WIDTH-1]};
    sub_y = {1'b0, a_q};
    if (state_q == fmr_pkg::EN_REDUCE) begin
      if (a_gt_b) begin
        sub_x = {1'b0, a_q};
        sub_y = {1'b0, b_q};
      end else begin
        sub_x = {1'b0, b_q};
        sub_y = {1'b0, a_q};
      end
    end
  end

  assign diff   = sub_x - sub_y;
  assign borrow = diff[PROD_WIDTH];

  always_comb begin
    if (!borrow) begin
      step_rem = diff[PROD_WIDTH-1:0];
      step_quo = {quo_q[PROD_WIDTH-2:0], 1'b1};
    end else begin
      step_rem = {rem_q[PROD_WIDTH-2:0], quo_q[PROD_WIDTH-1]};
      step_quo = {quo_q[PROD_WIDTH-2:0], 1'b0};
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fmr_pkg::EN_IDLE: begin
        if (start_i) state_d = fmr_pkg::EN_TWOS;
      end
      fmr_pkg::EN_TWOS: begin
        if (!both_even) state_d = fmr_pkg::EN_REDUCE;
      end
      fmr_pkg::EN_REDUCE: begin
        if (a_eq_b) state_d = fmr_pkg::EN_DIV_NUM;
      end
      fmr_pkg::EN_DIV_NUM: begin
        if (div_last) state_d = fmr_pkg::EN_DIV_DEN;
      end
      fmr_pkg::EN_DIV_DEN: begin
        if (div_last) state_d = fmr_pkg::EN_DONE;
      end
      fmr_pkg::EN_DONE: begin
        state_d = fmr_pkg::EN_IDLE;
      end
      default: begin
        state_d = fmr_pkg::EN_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    done_o    = state_q == fmr_pkg::EN_DONE;
    quo_num_o = qn_q;
    quo_den_o = quo_q;
  end

  // Datapath
  always_comb begin
    a_d   = a_q;
    b_d   = b_q;
    rn_d  = rn_q;
    rd_d  = rd_q;
    rem_d = rem_q;
    quo_d = quo_q;
    qn_d  = qn_q;
    cnt_d = cnt_q;
    case (state_q)
      fmr_pkg::EN_IDLE: begin
        if (start_i) begin
          a_d = pn_i;
          b_d = pd_i;
        end
      end
      fmr_pkg::EN_TWOS: begin
        // Strip common powers of two from both products; the quotients stay exact
        if (both_even) begin
          a_d = a_q >> 1;
          b_d = b_q >> 1;
        end else begin
          rn_d = a_q;
          rd_d = b_q;
        end
      end
      fmr_pkg::EN_REDUCE: begin
        if (a_eq_b) begin
          quo_d = rn_q;
          rem_d = '0;
          cnt_d = '0;
        end else if (!a_q[0]) begin
          a_d = a_q >> 1;
        end else if (!b_q[0]) begin
          b_d = b_q >> 1;
        end else if (a_gt_b) begin
          a_d = diff[PROD_WIDTH-1:0];
        end else begin
          b_d = diff[PROD_WIDTH-1:0];
        end
      end
      fmr_pkg::EN_DIV_NUM: begin
        rem_d = step_rem;
        quo_d = step_quo;
        cnt_d = cnt_q + 1'b1;
        if (div_last) begin
          qn_d  = step_quo;
          quo_d = rd_q;
          rem_d = '0;
          cnt_d = '0;
        end
      end
      fmr_pkg::EN_DIV_DEN: begin
        rem_d = step_rem;
        quo_d = step_quo;
        cnt_d = cnt_q + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fmr_pkg::EN_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    rn_q  <= rn_d;
    rd_q  <= rd_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    qn_q  <= qn_d;
    cnt_q <= cnt_d;
  end

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == fmr_pkg::EN_IDLE)
    else $error("engine started while busy");

  a_gcd_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == fmr_pkg::EN_REDUCE |-> (a_q != '0) && (b_q != '0))
    else $error("gcd operand reached zero");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fmr_pkg::EN_DIV_NUM || state_q == fmr_pkg::EN_DIV_DEN) |-> rem_q < a_q)
    else $error("partial remainder not below divisor");

endmodule

>>> src/fraction_multiply_reduce.sv
// Steps: numerator and denominator products on one multiplier, stripping of shared twos,
// binary gcd, then restoring division of both products, all on W = 2*min(OPERAND_WIDTH, 16)
// bit products, with the sequencer's control states around them.
// Throughput: one word at a time; the shared subtract unit sets the rate. A word with a
// zero operand skips multiply and engine. in_ready_o is low until the result is registered.
// Reset: rst_ni asynchronous, active low; clears sequencer and output valid, no clearing pass.
`timescale 1ns / 1ps

module fraction_multiply_reduce #(
  parameter int OPERAND_WIDTH = fmr_pkg::DefaultOperandWidth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  fmr_pkg::in_t   in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output fmr_pkg::out_t  out_o
);

  localparam int EffW  = (OPERAND_WIDTH < fmr_pkg::OperandWidth) ?
                         OPERAND_WIDTH : fmr_pkg::OperandWidth;
  localparam int ProdW = 2 * EffW;

  fmr_pkg::fmr_state_e state_q, state_d;

  logic [EffW-1:0]  na_q, da_q, nb_q, db_q;
  logic [ProdW-1:0] pn_q, pd_q;
  logic [ProdW-1:0] res_num_q, res_den_q;
  logic             res_err_q;
  logic             out_valid_q, out_valid_d;
  fmr_pkg::out_t    out_q;

  logic [EffW-1:0]  na_m, da_m, nb_m, db_m;
  logic             in_fire;
  logic             in_zero;
  logic             out_free;
  logic             out_load;
  logic             sel_den;
  logic             eng_start;
  logic             eng_done;
  logic [EffW-1:0]  mul_x, mul_y;
  logic [ProdW-1:0] mul_p;
  logic [ProdW-1:0] quo_num, quo_den;

  assign na_m = in_i.num_a[EffW-1:0];
  assign da_m = in_i.den_a[EffW-1:0];
  assign nb_m = in_i.num_b[EffW-1:0];
  assign db_m = in_i.den_b[EffW-1:0];

  assign in_fire  = in_valid_i && in_ready_o;
  assign in_zero  = (na_m == '0) || (da_m == '0) || (nb_m == '0) || (db_m == '0);
  assign out_free = !out_valid_q || out_ready_i;

  // One multiplier, used for the numerator product and then the denominator product
  assign mul_x = sel_den ? da_q : na_q;
  assign mul_y = sel_den ? db_q : nb_q;
  assign mul_p = ProdW'(mul_x) * ProdW'(mul_y);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fmr_pkg::ST_IDLE: begin
        if (in_fire) state_d = in_zero ? fmr_pkg::ST_PUSH : fmr_pkg::ST_MUL_NUM;
      end
      fmr_pkg::ST_MUL_NUM: state_d = fmr_pkg::ST_MUL_DEN;
      fmr_pkg::ST_MUL_DEN: state_d = fmr_pkg::ST_START;
      fmr_pkg::ST_START:   state_d = fmr_pkg::ST_RUN;
      fmr_pkg::ST_RUN: begin
        if (eng_done) state_d = fmr_pkg::ST_PUSH;
      end
      fmr_pkg::ST_PUSH: begin
        if (out_free) state_d = fmr_pkg::ST_IDLE;
      end
      default: state_d = fmr_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready_o = state_q == fmr_pkg::ST_IDLE;
    sel_den    = state_q == fmr_pkg::ST_MUL_DEN;
    eng_start  = state_q == fmr_pkg::ST_START;
    out_load   = (state_q == fmr_pkg::ST_PUSH) && out_free;
  end

  fmr_engine #(
    .PROD_WIDTH(ProdW)
  ) u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (eng_start),
    .pn_i      (pn_q),
    .pd_i      (pd_q),
    .done_o    (eng_done),
    .quo_num_o (quo_num),
    .quo_den_o (quo_den)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fmr_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      na_q      <= na_m;
      da_q      <= da_m;
      nb_q      <= nb_m;
      db_q      <= db_m;
      res_num_q <= '0;
      res_den_q <= '0;
      res_err_q <= in_zero;
    end
    if (state_q == fmr_pkg::ST_MUL_NUM) pn_q <= mul_p;
    if (state_q == fmr_pkg::ST_MUL_DEN) pd_q <= mul_p;
    if ((state_q == fmr_pkg::ST_RUN) && eng_done) begin
      res_num_q <= quo_num;
      res_den_q <= quo_den;
    end
    if (out_load) begin
      out_q.num_out    <= fmr_pkg::ResultWidth'(res_num_q);
      out_q.den_out    <= fmr_pkg::ResultWidth'(res_den_q);
      out_q.zero_error <= res_err_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_zero_skips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_zero |=> state_q == fmr_pkg::ST_PUSH && res_err_q)
    else $error("zero operand did not bypass the engine");

  a_err_zeros: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.zero_error |-> out_o.num_out == '0 && out_o.den_out == '0)
    else $error("error word carries a nonzero fraction");

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.zero_error |-> out_o.den_out != '0)
    else $error("reduced denominator is zero");

endmodule
